[rtl/tmpl_pkg.sv]
// ----------------------------------------------------------------------------
// tmpl_pkg
// Shared types and constants for the threshold max profit lookup block.
// ----------------------------------------------------------------------------
package tmpl_pkg;

	localparam int unsigned MAX_JOBS_DEF = 256;
	localparam int unsigned FIELD_W      = 20;
	localparam int unsigned TOTAL_W      = 48;
	localparam int unsigned OP_W         = 2;
	localparam int unsigned IN_TDATA_W   = 64;
	localparam int unsigned OUT_TDATA_W  = 72;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_ADD
	} state_t;

	typedef struct packed {
		logic [FIELD_W-1:0] profit;
		logic [FIELD_W-1:0] difficulty;
	} job_entry_t;

	typedef struct packed {
		logic init;
		logic step;
	} scan_ctl_t;

endpackage

[rtl/tmpl_job_mem.sv]
// ----------------------------------------------------------------------------
// tmpl_job_mem
// Job table memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tmpl_job_mem #(
	parameter int unsigned DEPTH = tmpl_pkg::MAX_JOBS_DEF,
	parameter int unsigned AW    = 8
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  tmpl_pkg::job_entry_t wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output tmpl_pkg::job_entry_t rd_data
);
	import tmpl_pkg::*;

	job_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/tmpl_scan.sv]
// ----------------------------------------------------------------------------
// tmpl_scan
// Shared compare unit: tests one job against the ability per cycle and keeps
// the greatest eligible profit seen so far.
// ----------------------------------------------------------------------------
module tmpl_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tmpl_pkg::scan_ctl_t           ctl,
	input  logic [tmpl_pkg::FIELD_W-1:0]  ability,
	input  tmpl_pkg::job_entry_t          entry,
	output logic [tmpl_pkg::FIELD_W-1:0]  best,
	output logic                          found
);
	import tmpl_pkg::*;

	logic [FIELD_W-1:0] best_q;
	logic               found_q;
	logic               eligible;
	logic               better;

	assign eligible = (entry.difficulty <= ability);
	assign better   = !found_q || (entry.profit > best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q  <= '0;
			found_q <= 1'b0;
		end else if (ctl.init) begin
			best_q  <= '0;
			found_q <= 1'b0;
		end else if (ctl.step && eligible) begin
			if (better) begin
				best_q <= entry.profit;
			end
			found_q <= 1'b1;
		end
	end

	assign best  = best_q;
	assign found = found_q;

endmodule

[rtl/threshold_max_profit_lookup.sv]
// ----------------------------------------------------------------------------
// threshold_max_profit_lookup
// A clear or a job load leaves the block idle. During a worker query the single
// read port of the job memory delivers one stored job per cycle to a shared
// compare unit. A wait state then covers the last compare, and an add state the
// saturating add of the best profit to the running total. On an empty table a
// query goes straight to the add state. The add waits while the previous result
// has not yet been taken. The input side is not ready while a query runs. A
// finished result waits in an output register, so the next item may be accepted
// meanwhile.
// ----------------------------------------------------------------------------
module threshold_max_profit_lookup #(
	parameter int unsigned MAX_JOBS = tmpl_pkg::MAX_JOBS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// job_difficulty [19:0], job_profit [39:20], worker_ability [59:40]
	input  logic [tmpl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// opcode [1:0]
	input  logic [tmpl_pkg::OP_W-1:0]          s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// best_profit [19:0], total_profit [67:20]
	output logic [tmpl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// job_found [0]
	output logic                               m_axis_tuser
);
	import tmpl_pkg::*;

	localparam int unsigned CW = $clog2(MAX_JOBS + 1);
	localparam int unsigned AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

	state_t             state_q;
	state_t             state_d;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [FIELD_W-1:0] ability_q;
	logic [TOTAL_W-1:0] total_q;
	logic               rd_vld_s1;

	logic [FIELD_W-1:0] in_diff;
	logic [FIELD_W-1:0] in_prof;
	logic [FIELD_W-1:0] in_ability;
	opcode_t            in_op;
	logic               in_xfer;
	logic               last_read;
	logic               table_full;

	logic               rd_en;
	logic               out_load;
	scan_ctl_t          scan_ctl;
	job_entry_t         wr_entry;
	job_entry_t         rd_entry;
	logic [FIELD_W-1:0] best;
	logic               found;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] new_total;

	logic [FIELD_W-1:0] out_best_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic               out_found_q;
	logic               m_valid_q;

	assign in_diff    = s_axis_tdata[FIELD_W-1:0];
	assign in_prof    = s_axis_tdata[2*FIELD_W-1:FIELD_W];
	assign in_ability = s_axis_tdata[3*FIELD_W-1:2*FIELD_W];
	assign in_op      = opcode_t'(s_axis_tuser);
	assign in_xfer    = s_axis_tvalid && s_axis_tready;
	assign last_read  = (CW'(idx_q + CW'(1)) == count_q);
	assign table_full = (count_q == CW'(MAX_JOBS));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && (in_op == OP_QUERY)) begin
					state_d = (count_q == '0) ? ST_ADD : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_read) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		rd_en         = (state_q == ST_SCAN);
		out_load      = (state_q == ST_ADD) && (!m_valid_q || m_axis_tready);
		scan_ctl.init = in_xfer && (in_op == OP_QUERY);
		scan_ctl.step = rd_vld_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			total_q   <= '0;
			rd_vld_s1 <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (in_xfer) begin
				case (in_op)
					OP_CLEAR: begin
						count_q <= '0;
						total_q <= '0;
					end
					OP_LOAD: begin
						if (!table_full) begin
							count_q <= CW'(count_q + CW'(1));
						end
					end
					OP_QUERY: begin
						idx_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (rd_en) begin
				idx_q <= CW'(idx_q + CW'(1));
			end
			if (out_load) begin
				total_q   <= new_total;
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && (in_op == OP_QUERY)) begin
			ability_q <= in_ability;
		end
		if (out_load) begin
			out_best_q  <= best;
			out_found_q <= found;
			out_total_q <= new_total;
		end
	end

	assign wr_entry.difficulty = in_diff;
	assign wr_entry.profit     = in_prof;

	tmpl_job_mem #(
		.DEPTH (MAX_JOBS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (in_xfer && (in_op == OP_LOAD) && !table_full),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_entry)
	);

	tmpl_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scan_ctl),
		.ability (ability_q),
		.entry   (rd_entry),
		.best    (best),
		.found   (found)
	);

	assign sum       = {1'b0, total_q} + (TOTAL_W + 1)'(best);
	assign new_total = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - TOTAL_W - FIELD_W)'(0), out_total_q, out_best_q};
	assign m_axis_tuser  = out_found_q;

endmodule

[rtl/tmpl_checker.sv]
// ----------------------------------------------------------------------------
// tmpl_checker
// Port-level checks for the threshold max profit lookup block, bound to the
// top level.
// ----------------------------------------------------------------------------
module tmpl_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic [tmpl_pkg::OP_W-1:0]          s_axis_tuser,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [tmpl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input logic                               m_axis_tuser
);
	import tmpl_pkg::*;

	logic in_xfer;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// A result that is not taken stays in place unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// With no eligible job the reported profit is zero.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[FIELD_W-1:0] == '0)
		else $error("nonzero profit without an eligible job");

	// A query keeps the input side busy in the following cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (s_axis_tuser == OP_QUERY) |=> !s_axis_tready)
		else $error("input ready right after a query transfer");

	// After a clear or a load the input side is ready again in the following cycle.
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (s_axis_tuser == OP_LOAD || s_axis_tuser == OP_CLEAR) |=> s_axis_tready)
		else $error("input not ready after a clear or load transfer");

endmodule

bind threshold_max_profit_lookup tmpl_checker u_tmpl_checker (.*);

[bench/profit_lookup_checker.sv]
// ----------------------------------------------------------------------------
// profit_lookup_checker
// Watches both stream channels of the profit lookup block. It keeps its own
// copy of the job table and of the running total, works out the answer to
// every accepted worker query, and compares each delivered result with the
// oldest outstanding answer, one field at a time.
// ----------------------------------------------------------------------------
module profit_lookup_checker #(
	parameter int unsigned MAX_JOBS = tmpl_pkg::MAX_JOBS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	input  logic [tmpl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input  logic [tmpl_pkg::OP_W-1:0]          s_axis_tuser,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic [tmpl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic                               m_axis_tuser,
	output int unsigned                        error_count,
	output int unsigned                        results_pending,
	output int unsigned                        results_checked,
	output int unsigned                        loads_dropped
);
	timeunit 1ns;
	timeprecision 1ps;

	import tmpl_pkg::*;

	localparam int unsigned DIFF_LSB    = 0;
	localparam int unsigned PROFIT_LSB  = FIELD_W;
	localparam int unsigned ABILITY_LSB = 2 * FIELD_W;
	localparam int unsigned TOTAL_LSB   = FIELD_W;
	localparam logic [TOTAL_W-1:0] TOTAL_CEILING = '1;

	typedef struct {
		logic [FIELD_W-1:0] best;
		logic               found;
		logic [TOTAL_W-1:0] total;
	} lookup_result_t;

	logic [FIELD_W-1:0] table_difficulty [MAX_JOBS];
	logic [FIELD_W-1:0] table_profit [MAX_JOBS];
	int unsigned        table_fill;
	logic [TOTAL_W-1:0] profit_sum;
	lookup_result_t     awaited_results [$];
	int unsigned        mismatches;
	int unsigned        checked;
	int unsigned        dropped;

	initial begin
		error_count = 0;
		results_pending = 0;
		results_checked = 0;
		loads_dropped = 0;
		mismatches = 0;
		checked = 0;
		dropped = 0;
		table_fill = 0;
		profit_sum = '0;
	end

	// Finds the best eligible job and folds its profit into the running total.
	function automatic lookup_result_t settle_query(input logic [FIELD_W-1:0] ability);
		lookup_result_t answer;
		logic [TOTAL_W:0] sum;
		answer.best = '0;
		answer.found = 1'b0;
		for (int unsigned i = 0; i < table_fill; i++) begin
			if (table_difficulty[i] <= ability) begin
				if (!answer.found || table_profit[i] > answer.best) begin
					answer.best = table_profit[i];
				end
				answer.found = 1'b1;
			end
		end
		sum = {1'b0, profit_sum} + (TOTAL_W + 1)'(answer.best);
		profit_sum = sum[TOTAL_W] ? TOTAL_CEILING : sum[TOTAL_W-1:0];
		answer.total = profit_sum;
		return answer;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		lookup_result_t want;
		logic [FIELD_W-1:0] got_best;
		logic [TOTAL_W-1:0] got_total;
		got_best = m_axis_tdata[FIELD_W-1:0];
		got_total = m_axis_tdata[TOTAL_LSB +: TOTAL_W];
		if (!arst_n) begin
			table_fill = 0;
			profit_sum = '0;
			awaited_results.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					$error("result with no query outstanding: best_profit %0d job_found %0d total_profit %0d",
						got_best, m_axis_tuser, got_total);
				end else begin
					want = awaited_results.pop_front();
					checked++;
					if (got_best !== want.best) begin
						mismatches++;
						$error("best_profit: expected %0d, got %0d", want.best, got_best);
					end
					if (m_axis_tuser !== want.found) begin
						mismatches++;
						$error("job_found: expected %0d, got %0d", want.found, m_axis_tuser);
					end
					if (got_total !== want.total) begin
						mismatches++;
						$error("total_profit: expected %0d, got %0d", want.total, got_total);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				case (opcode_t'(s_axis_tuser))
					OP_CLEAR: begin
						table_fill = 0;
						profit_sum = '0;
					end
					OP_LOAD: begin
						if (table_fill < MAX_JOBS) begin
							table_difficulty[table_fill] = s_axis_tdata[DIFF_LSB +: FIELD_W];
							table_profit[table_fill] = s_axis_tdata[PROFIT_LSB +: FIELD_W];
							table_fill++;
						end else begin
							dropped++;
						end
					end
					OP_QUERY: begin
						awaited_results.push_back(settle_query(s_axis_tdata[ABILITY_LSB +: FIELD_W]));
					end
					default: begin
					end
				endcase
			end
		end
		error_count <= mismatches;
		results_pending <= awaited_results.size();
		results_checked <= checked;
		loads_dropped <= dropped;
	end

endmodule

[bench/tb_threshold_max_profit_lookup.sv]
// ----------------------------------------------------------------------------
// tb_threshold_max_profit_lookup
// Drives job loads, worker queries, clears and ignored opcodes into the profit
// lookup block: a directed opening, then random episodes that each start from
// a clear, mostly with small tables and a few that fill the table past its
// capacity. Both stream sides idle at random in changing proportions. A
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_threshold_max_profit_lookup;
	timeunit 1ns;
	timeprecision 1ps;

	import tmpl_pkg::*;

	localparam int unsigned JOBS         = MAX_JOBS_DEF;
	localparam int unsigned ITEM_TARGET  = 1800;
	localparam int unsigned DRAIN_CYCLES = JOBS + 16;
	localparam int unsigned FULL_FILLS   = 3;
	localparam logic [OP_W-1:0]    OP_IGNORED = 2'd3;
	localparam logic [FIELD_W-1:0] FIELD_MAX  = '1;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
	logic [OP_W-1:0]          s_axis_tuser = OP_CLEAR;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]   m_axis_tdata;
	logic                     m_axis_tuser;

	int unsigned error_count;
	int unsigned results_pending;
	int unsigned results_checked;
	int unsigned loads_dropped;

	int unsigned tx_idle_pct = 37;
	int unsigned rx_idle_pct = 87;
	int unsigned sent_items = 0;
	int unsigned sent_loads = 0;
	int unsigned sent_queries = 0;
	int unsigned sent_clears = 0;
	int unsigned sent_ignored = 0;
	int unsigned full_episodes = 0;
	logic [FIELD_W-1:0] episode_difficulties [$];

	threshold_max_profit_lookup #(
		.MAX_JOBS(JOBS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	profit_lookup_checker #(
		.MAX_JOBS(JOBS)
	) lookup_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.error_count(error_count),
		.results_pending(results_pending),
		.results_checked(results_checked),
		.loads_dropped(loads_dropped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] difficulty,
		input logic [FIELD_W-1:0] profit, input logic [FIELD_W-1:0] ability);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {{(IN_TDATA_W - 3 * FIELD_W){1'b0}}, ability, profit, difficulty};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		case (op)
			OP_CLEAR: sent_clears++;
			OP_LOAD: sent_loads++;
			OP_QUERY: sent_queries++;
			default: sent_ignored++;
		endcase
		sent_items = sent_clears + sent_loads + sent_queries;
		if (sent_items >= 2 * ITEM_TARGET / 3) begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end else if (sent_items >= ITEM_TARGET / 3) begin
			tx_idle_pct = 87;
			rx_idle_pct = 37;
		end
	endtask

	task automatic clear_table();
		send_item(OP_CLEAR, FIELD_W'($urandom()), FIELD_W'($urandom()), FIELD_W'($urandom()));
		episode_difficulties.delete();
	endtask

	task automatic load_job(input logic [FIELD_W-1:0] difficulty, input logic [FIELD_W-1:0] profit);
		send_item(OP_LOAD, difficulty, profit, FIELD_W'($urandom()));
		episode_difficulties.push_back(difficulty);
	endtask

	task automatic query_worker(input logic [FIELD_W-1:0] ability);
		send_item(OP_QUERY, FIELD_W'($urandom()), FIELD_W'($urandom()), ability);
	endtask

	initial begin
		logic [FIELD_W-1:0] diff_mask;
		logic [FIELD_W-1:0] profit_mask;
		logic [FIELD_W-1:0] ability;
		int unsigned loads_left;
		int unsigned queries_left;
		int unsigned pick;
		bit fill_table;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Queries on an empty table, then the field extremes and profit ties.
		query_worker(FIELD_MAX);
		query_worker('0);
		send_item(OP_IGNORED, FIELD_MAX, FIELD_MAX, FIELD_MAX);
		load_job('0, FIELD_MAX);
		load_job(FIELD_MAX, '0);
		query_worker('0);
		clear_table();
		query_worker(FIELD_MAX);
		load_job(20'd100, 20'd500);
		load_job(20'd200, 20'd500);
		load_job(20'd150, 20'd300);
		query_worker(20'd99);
		query_worker(20'd100);
		query_worker(20'd250);
		load_job(FIELD_MAX, FIELD_MAX);
		query_worker(FIELD_MAX);
		query_worker(FIELD_MAX - FIELD_W'(1));
		send_item(OP_IGNORED, '0, '0, '0);
		query_worker(20'd150);

		while (sent_items < ITEM_TARGET) begin
			fill_table = (full_episodes < FULL_FILLS) && ($urandom_range(0, 24) == 0
				|| (full_episodes == 0 && sent_items > ITEM_TARGET / 2));
			case ($urandom_range(0, 2))
				0: diff_mask = FIELD_MAX;
				1: diff_mask = 20'h003FF;
				default: diff_mask = 20'h0000F;
			endcase
			case ($urandom_range(0, 2))
				0: profit_mask = FIELD_MAX;
				1: profit_mask = 20'h000FF;
				default: profit_mask = 20'h00007;
			endcase
			clear_table();
			if (fill_table) begin
				full_episodes++;
				loads_left = JOBS + $urandom_range(1, 6);
				queries_left = $urandom_range(4, 8);
			end else begin
				loads_left = $urandom_range(0, 20);
				queries_left = $urandom_range(2, 24);
			end
			while (loads_left + queries_left != 0) begin
				if ($urandom_range(0, 19) == 0) begin
					send_item(OP_IGNORED, FIELD_W'($urandom()), FIELD_W'($urandom()),
						FIELD_W'($urandom()));
				end else if (!fill_table && $urandom_range(0, 79) == 0) begin
					clear_table();
				end else if (loads_left != 0
					&& (fill_table || queries_left == 0 || $urandom_range(0, 2) != 0)) begin
					load_job(FIELD_W'($urandom()) & diff_mask, FIELD_W'($urandom()) & profit_mask);
					loads_left--;
				end else begin
					ability = FIELD_W'($urandom()) & diff_mask;
					pick = $urandom_range(0, 5);
					if (pick == 0) begin
						ability = '0;
					end else if (pick == 1) begin
						ability = FIELD_MAX;
					end else if (pick <= 3 && episode_difficulties.size() != 0) begin
						ability = episode_difficulties[$urandom_range(0,
							episode_difficulties.size() - 1)];
						if (pick == 3 && ability != '0) begin
							ability = ability - FIELD_W'(1);
						end
					end
					query_worker(ability);
					queries_left--;
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d clears, %0d job loads (%0d dropped on a full table), %0d queries",
			sent_clears, sent_loads, loads_dropped, sent_queries);
		$display("and %0d ignored opcodes; %0d results checked over %0d full-table fills.",
			sent_ignored, results_checked, full_episodes);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
